@@ hdl/wsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer: parse phases,
// result kinds, field widths and the result record passed between stages.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Width of the payload length held by the block (16 to 32).
  localparam int LENGTH_BITS = 24;
  // Width of the maximum-length configuration register.
  localparam int CFG_W       = 24;
  // Width used when comparing a length against the configured maximum.
  localparam int CMP_W       = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;

  localparam logic [CFG_W-1:0] MAX_LEN_RESET = CFG_W'(1000000);

  localparam logic [3:0] OPCODE_TEXT  = 4'h1;
  localparam logic [3:0] OPCODE_CLOSE = 4'h8;
  localparam logic [6:0] LEN7_EXT16   = 7'd126;
  localparam logic [6:0] LEN7_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES  = 4'd2;
  localparam logic [3:0] EXT64_BYTES  = 4'd8;
  localparam logic [3:0] MASK_BYTES   = 4'd4;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_DISCONNECT = 2'd1,
    KIND_BAD_OPCODE = 2'd2,
    KIND_TOO_LARGE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

endpackage

@@ hdl/wsd_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module wsd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       stage_valid,
  output logic [7:0] stage_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      byte_nxt  = in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign stage_valid = valid_r;
  assign stage_byte  = byte_r;

endmodule

@@ hdl/wsd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser and payload unmasker. Consumes one byte per firing and
// produces at most one result, updating the parse state in the same cycle.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [wsd_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                  fire,
  input  logic [7:0]            rx_byte,
  output logic                  res_valid,
  output wsd_pkg::result_t      res
);
  import wsd_pkg::*;

  logic [CFG_W-1:0]       max_len_r;
  phase_t                 phase_r, phase_nxt;
  logic [3:0]             count_r, count_nxt;
  logic                   ext_long_r, ext_long_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [LENGTH_BITS-1:0] remain_r, remain_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic                   halted_r, halted_nxt;

  logic [6:0]             len7;
  logic [3:0]             count_inc;
  logic [3:0]             ext_need;
  logic                   len_complete;
  logic                   too_large;
  logic [7:0]             key_byte;

  assign len7      = rx_byte[6:0];
  assign count_inc = count_r + 4'd1;
  assign ext_need  = ext_long_r ? EXT64_BYTES : EXT16_BYTES;

  // Mask byte 0 sits in the top byte of the key.
  always_comb begin
    case (idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    ext_long_nxt = ext_long_r;
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    key_nxt      = key_r;
    remain_nxt   = remain_r;
    idx_nxt      = idx_r;
    halted_nxt   = halted_r;
    len_complete = 1'b0;
    too_large    = 1'b0;
    res_valid    = 1'b0;
    res.data     = 8'h00;
    res.kind     = KIND_DATA;
    res.last     = 1'b0;

    if (fire && !halted_r) begin
      case (phase_r)
        PH_LEN: begin
          if (len7 < LEN7_EXT16) begin
            len_nxt      = LENGTH_BITS'(len7);
            ovf_nxt      = 1'b0;
            len_complete = 1'b1;
          end else begin
            len_nxt      = '0;
            ovf_nxt      = 1'b0;
            count_nxt    = 4'd0;
            ext_long_nxt = (len7 == LEN7_EXT64);
            phase_nxt    = PH_EXT;
          end
        end
        PH_EXT: begin
          // Bits pushed out of the top make the length too large for good.
          ovf_nxt   = ovf_r || (len_r[LENGTH_BITS-1 -: 8] != 8'h00);
          len_nxt   = {len_r[LENGTH_BITS-9:0], rx_byte};
          count_nxt = count_inc;
          if (count_inc >= ext_need) begin
            len_complete = 1'b1;
          end
        end
        PH_MASK: begin
          key_nxt   = {key_r[23:0], rx_byte};
          count_nxt = count_inc;
          if (count_inc >= MASK_BYTES) begin
            count_nxt  = 4'd0;
            idx_nxt    = 2'd0;
            remain_nxt = len_r;
            phase_nxt  = (len_r == '0) ? PH_OPCODE : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          res.data  = rx_byte ^ key_byte;
          res.kind  = KIND_DATA;
          res.last  = (remain_r <= LENGTH_BITS'(1));
          idx_nxt   = idx_r + 2'd1;
          if (remain_r <= LENGTH_BITS'(1)) begin
            remain_nxt = '0;
            phase_nxt  = PH_OPCODE;
          end else begin
            remain_nxt = remain_r - LENGTH_BITS'(1);
          end
        end
        default: begin
          // Opcode byte; unknown phase codes are handled the same way.
          if (rx_byte[3:0] == OPCODE_TEXT) begin
            phase_nxt = PH_LEN;
          end else begin
            res_valid  = 1'b1;
            res.kind   = (rx_byte[3:0] == OPCODE_CLOSE) ? KIND_DISCONNECT
                                                        : KIND_BAD_OPCODE;
            halted_nxt = 1'b1;
          end
        end
      endcase

      too_large = ovf_nxt || (CMP_W'(len_nxt) > CMP_W'(max_len_r));

      if (len_complete) begin
        if (too_large) begin
          res_valid  = 1'b1;
          res.kind   = KIND_TOO_LARGE;
          halted_nxt = 1'b1;
        end else begin
          phase_nxt = PH_MASK;
          count_nxt = 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= MAX_LEN_RESET;
      phase_r    <= PH_OPCODE;
      count_r    <= 4'd0;
      ext_long_r <= 1'b0;
      len_r      <= '0;
      ovf_r      <= 1'b0;
      key_r      <= 32'h0;
      remain_r   <= '0;
      idx_r      <= 2'd0;
      halted_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      ext_long_r <= ext_long_nxt;
      len_r      <= len_nxt;
      ovf_r      <= ovf_nxt;
      key_r      <= key_nxt;
      remain_r   <= remain_nxt;
      idx_r      <= idx_nxt;
      halted_r   <= halted_nxt;
    end
  end

endmodule

@@ hdl/wsd_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  wsd_pkg::result_t res,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_kind,
  output logic             out_last_of_frame
);
  import wsd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (space) begin
      valid_nxt = res_valid;
      res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid         = valid_r;
  assign out_byte          = res_r.data;
  assign out_kind          = res_r.kind;
  assign out_last_of_frame = res_r.last;

endmodule

@@ hdl/websocket_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses client-to-server WebSocket frames byte by byte and unmasks payload.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on the in_ channel (valid/ready), one byte per
// transaction. Each payload byte leaves on the out_ channel unmasked, with
// out_kind at zero and out_last_of_frame set on the final byte of a frame.
// Header bytes produce no transaction. A close opcode, an unknown opcode or a
// length above the set maximum gives one status transaction (out_kind 1, 2 or
// 3, data zero) after which the block halts and discards all input until
// reset. The maximum length is written through cfg_wr_en/cfg_wr_data while
// the block is idle; it resets to 1000000.
// Throughput: one byte per clock cycle unless the receiver stalls, set by
// the single parse step between the input register and the result register.
// Path: an accepted byte is held in the input register and parsed from
// there; its result is captured in the result register, which presents it
// on the out_ channel.
// Reset (synchronous, active low) empties both registers and returns the
// parser to expecting an opcode byte. When the receiver stalls, the result
// register holds its transaction and one more byte may wait in the input
// register; in_ready then falls until the receiver takes the result.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [wsd_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic [1:0]                out_kind,
  output logic                      out_last_of_frame
);
  import wsd_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       space;
  logic       fire;
  logic       res_valid;
  result_t    res;

  // The held byte is parsed whenever the result register can take whatever
  // it produces; bytes that produce nothing advance the same way.
  assign fire = stage_valid && space;

  wsd_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .take        (fire),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  wsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .rx_byte     (stage_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsd_out_stage u_out_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res_valid),
    .res               (res),
    .space             (space),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_kind          (out_kind),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
